// ===== design/lsr_pkg.sv =====
// Shared types and constants of the line segment resampler.
// No dependencies; every other design file imports this package.
`default_nettype none

package lsr_pkg;

    localparam int COORD_W   = 24;
    localparam int DIFF_W    = 25;
    localparam int SQ_W      = 50;
    localparam int ROOT_W    = 51;
    localparam int DIST_W    = 25;
    localparam int UNIT_W    = 17;
    localparam int WALK_W    = 26;
    localparam int PROD_W    = 43;
    localparam int SUM_W     = 29;
    localparam int STEP_W    = 24;
    localparam logic [STEP_W-1:0] SPACING_RESET = 24'd8960;
    localparam logic [4:0] ROOT_STEPS_M1 = 5'd24;
    localparam logic [4:0] DIV_STEPS_M1  = 5'd16;

    // One classified segment, handed from the front to the back.
    typedef struct packed {
        logic [COORD_W-1:0] start_x;
        logic [COORD_W-1:0] start_y;
        logic [COORD_W-1:0] end_x;
        logic [COORD_W-1:0] end_y;
        logic [DIST_W-1:0]  seg_len;
        logic [UNIT_W-1:0]  ux_mag;
        logic               ux_neg;
        logic [UNIT_W-1:0]  uy_mag;
        logic               uy_neg;
    } lsr_job_t;

    typedef enum logic [2:0] {
        F_IDLE, F_DIFF, F_SQR, F_SUM, F_ROOT, F_DSET, F_DIV, F_PUSH
    } lsr_front_state_t;

    typedef enum logic [2:0] {
        B_IDLE, B_MUL, B_EMIT, B_CHECK, B_LAST
    } lsr_back_state_t;

endpackage

`default_nettype wire

// ===== design/lsr_ifs.sv =====
// Channel interfaces: segment input, point output and spacing write.
// Depends on lsr_pkg for field widths.
`default_nettype none

interface lsr_seg_if;
    import lsr_pkg::*;
    logic               valid;
    logic               ready;
    logic [COORD_W-1:0] start_x;
    logic [COORD_W-1:0] start_y;
    logic [COORD_W-1:0] end_x;
    logic [COORD_W-1:0] end_y;
    modport source (output valid, start_x, start_y, end_x, end_y, input ready);
    modport sink (input valid, start_x, start_y, end_x, end_y, output ready);
endinterface

interface lsr_pt_if;
    import lsr_pkg::*;
    logic               valid;
    logic               ready;
    logic [COORD_W-1:0] point_x;
    logic [COORD_W-1:0] point_y;
    logic               is_last;
    logic               truncated;
    modport source (output valid, point_x, point_y, is_last, truncated, input ready);
    modport sink (input valid, point_x, point_y, is_last, truncated, output ready);
endinterface

interface lsr_cfg_if;
    import lsr_pkg::*;
    logic              valid;
    logic              ready;
    logic [STEP_W-1:0] data;
    modport source (output valid, data, input ready);
    modport sink (input valid, data, output ready);
endinterface

`default_nettype wire

// ===== design/lsr_front.sv =====
// Front end: takes a segment word, finds its length by a bit-serial square
// root and its unit vector by two serial divisions. Depends on lsr_pkg.
`default_nettype none

module lsr_front
    import lsr_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    lsr_seg_if.sink      seg,
    output lsr_job_t     job,
    output logic         job_valid,
    input  wire logic    job_ready
);

    lsr_front_state_t state_reg, state_next;
    lsr_job_t         job_reg, job_next;
    logic [DIFF_W-1:0] dx_reg, dx_next, dy_reg, dy_next;
    logic [SQ_W-1:0]   sqx_reg, sqx_next, sqy_reg, sqy_next;
    logic [SQ_W-1:0]   v_reg, v_next;
    logic [ROOT_W-1:0] res_reg, res_next;
    logic [4:0]        cnt_reg, cnt_next;
    logic              sel_y_reg, sel_y_next;
    logic [DIST_W-1:0] rem_reg, rem_next;
    logic [UNIT_W-1:0] low_reg, low_next;

    logic [ROOT_W-1:0] root_bit;
    logic [ROOT_W-1:0] root_try;
    logic [DIFF_W-1:0] div_mag;
    logic [41:0]       div_num;
    logic [DIST_W:0]   div_try;

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        job_reg   <= job_next;
        dx_reg    <= dx_next;
        dy_reg    <= dy_next;
        sqx_reg   <= sqx_next;
        sqy_reg   <= sqy_next;
        v_reg     <= v_next;
        res_reg   <= res_next;
        cnt_reg   <= cnt_next;
        sel_y_reg <= sel_y_next;
        rem_reg   <= rem_next;
        low_reg   <= low_next;
    end

    // Shared arithmetic terms of the root and divide steps.
    always_comb
    begin
        root_bit = ROOT_W'(1) << {cnt_reg, 1'b0};
        root_try = res_reg + root_bit;
        div_mag  = sel_y_reg ? (dy_reg[DIFF_W-1] ? -dy_reg : dy_reg)
                             : (dx_reg[DIFF_W-1] ? -dx_reg : dx_reg);
        div_num  = {1'b0, div_mag, 16'd0} + 42'(job_reg.seg_len >> 1);
        div_try  = {rem_reg, low_reg[UNIT_W-1]};
    end

    // Sequencer: next state and register updates.
    always_comb
    begin
        state_next = state_reg;
        job_next   = job_reg;
        dx_next    = dx_reg;
        dy_next    = dy_reg;
        sqx_next   = sqx_reg;
        sqy_next   = sqy_reg;
        v_next     = v_reg;
        res_next   = res_reg;
        cnt_next   = cnt_reg;
        sel_y_next = sel_y_reg;
        rem_next   = rem_reg;
        low_next   = low_reg;
        seg.ready  = 1'b0;
        job_valid  = 1'b0;
        case (state_reg)
            F_IDLE:
            begin
                seg.ready = 1'b1;
                if (seg.valid)
                begin
                    job_next.start_x = seg.start_x;
                    job_next.start_y = seg.start_y;
                    job_next.end_x   = seg.end_x;
                    job_next.end_y   = seg.end_y;
                    state_next       = F_DIFF;
                end
            end
            F_DIFF:
            begin
                dx_next = {job_reg.end_x[COORD_W-1], job_reg.end_x}
                        - {job_reg.start_x[COORD_W-1], job_reg.start_x};
                dy_next = {job_reg.end_y[COORD_W-1], job_reg.end_y}
                        - {job_reg.start_y[COORD_W-1], job_reg.start_y};
                state_next = F_SQR;
            end
            F_SQR:
            begin
                sqx_next   = SQ_W'($signed(dx_reg) * $signed(dx_reg));
                sqy_next   = SQ_W'($signed(dy_reg) * $signed(dy_reg));
                state_next = F_SUM;
            end
            F_SUM:
            begin
                v_next     = sqx_reg + sqy_reg;
                res_next   = '0;
                cnt_next   = ROOT_STEPS_M1;
                state_next = F_ROOT;
            end
            F_ROOT:
            begin
                // One result bit of the integer square root per cycle.
                if ({1'b0, v_reg} >= root_try)
                begin
                    v_next   = v_reg - SQ_W'(root_try);
                    res_next = (res_reg >> 1) + root_bit;
                end
                else
                begin
                    res_next = res_reg >> 1;
                end
                cnt_next = cnt_reg - 5'd1;
                if (cnt_reg == '0)
                begin
                    sel_y_next = 1'b0;
                    if (res_next == '0)
                    begin
                        job_next.seg_len = '0;
                        job_next.ux_mag  = '0;
                        job_next.ux_neg  = 1'b0;
                        job_next.uy_mag  = '0;
                        job_next.uy_neg  = 1'b0;
                        state_next       = F_PUSH;
                    end
                    else
                    begin
                        job_next.seg_len = res_next[DIST_W-1:0];
                        state_next       = F_DSET;
                    end
                end
            end
            F_DSET:
            begin
                // The top bits of the dividend are already below the length.
                rem_next   = div_num[41:17];
                low_next   = div_num[16:0];
                cnt_next   = DIV_STEPS_M1;
                state_next = F_DIV;
            end
            F_DIV:
            begin
                // Restoring division, one quotient bit per cycle.
                if (div_try >= {1'b0, job_reg.seg_len})
                begin
                    rem_next = DIST_W'(div_try - {1'b0, job_reg.seg_len});
                    low_next = {low_reg[UNIT_W-2:0], 1'b1};
                end
                else
                begin
                    rem_next = div_try[DIST_W-1:0];
                    low_next = {low_reg[UNIT_W-2:0], 1'b0};
                end
                cnt_next = cnt_reg - 5'd1;
                if (cnt_reg == '0)
                begin
                    if (sel_y_reg)
                    begin
                        job_next.uy_mag = low_next;
                        job_next.uy_neg = dy_reg[DIFF_W-1];
                        state_next      = F_PUSH;
                    end
                    else
                    begin
                        job_next.ux_mag = low_next;
                        job_next.ux_neg = dx_reg[DIFF_W-1];
                        sel_y_next      = 1'b1;
                        state_next      = F_DSET;
                    end
                end
            end
            F_PUSH:
            begin
                job_valid = 1'b1;
                if (job_ready)
                begin
                    state_next = F_IDLE;
                end
            end
            default:
            begin
                state_next = F_IDLE;
            end
        endcase
    end

    assign job = job_reg;

endmodule

`default_nettype wire

// ===== design/lsr_queue.sv =====
// Two-word queue of classified segments between the front and the back.
// Depends on lsr_pkg for the segment job type.
`default_nettype none

module lsr_queue
    import lsr_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire lsr_job_t push_job,
    input  wire logic     push_valid,
    output logic          push_ready,
    output lsr_job_t      pop_job,
    output logic          pop_valid,
    input  wire logic     pop_ready
);

    lsr_job_t   slot_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       do_push, do_pop;

    // Occupancy and pointer updates.
    always_comb
    begin
        push_ready  = (count_reg != 2'd2);
        pop_valid   = (count_reg != 2'd0);
        do_push     = push_valid && push_ready;
        do_pop      = pop_valid && pop_ready;
        wr_ptr_next = wr_ptr_reg ^ do_push;
        rd_ptr_next = rd_ptr_reg ^ do_pop;
        count_next  = count_reg + {1'b0, do_push} - {1'b0, do_pop};
        pop_job     = slot_reg[rd_ptr_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage.
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule

`default_nettype wire

// ===== design/lsr_back.sv =====
// Back end: walks one segment at the given spacing and drives the point
// output register, then the exact end point. Depends on lsr_pkg.
`default_nettype none

module lsr_back
    import lsr_pkg::*;
#(
    parameter int MAX_POINTS = 64
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire lsr_job_t          job,
    input  wire logic              job_valid,
    output logic                   job_ready,
    input  wire logic [STEP_W-1:0] spacing,
    lsr_pt_if.source               pt
);

    localparam int CNT_W = (MAX_POINTS > 2) ? $clog2(MAX_POINTS) : 1;
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(MAX_POINTS - 1);

    lsr_back_state_t state_reg, state_next;
    lsr_job_t         cur_reg, cur_next;
    logic [WALK_W-1:0] t_reg, t_next;
    logic [CNT_W-1:0]  n_reg, n_next;
    logic              trunc_reg, trunc_next;
    logic [PROD_W-1:0] prodx_reg, prodx_next, prody_reg, prody_next;
    logic              ovalid_reg, ovalid_next;
    logic [COORD_W-1:0] ox_reg, ox_next, oy_reg, oy_next;
    logic              olast_reg, olast_next, otrunc_reg, otrunc_next;
    logic              slot_free;
    logic [WALK_W-1:0] step;
    logic [COORD_W-1:0] px, py;

    // Rounded offset added to a start coordinate, saturated to 24 bits.
    function automatic logic [COORD_W-1:0] walk_coord(
        input logic [COORD_W-1:0] start,
        input logic [PROD_W-1:0]  prod,
        input logic               neg
    );
        logic [PROD_W-1:0] rnd;
        logic [SUM_W-1:0]  off;
        logic [SUM_W-1:0]  sum;
        rnd = prod + PROD_W'(17'h08000);
        off = SUM_W'(rnd >> 16);
        sum = {{(SUM_W-COORD_W){start[COORD_W-1]}}, start} + (neg ? -off : off);
        if ($signed(sum) > $signed(SUM_W'(24'sh7FFFFF)))
        begin
            return 24'h7FFFFF;
        end
        else if ($signed(sum) < -$signed(SUM_W'(24'h800000)))
        begin
            return 24'h800000;
        end
        return sum[COORD_W-1:0];
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= B_IDLE;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            ovalid_reg <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg    <= cur_next;
        t_reg      <= t_next;
        n_reg      <= n_next;
        trunc_reg  <= trunc_next;
        prodx_reg  <= prodx_next;
        prody_reg  <= prody_next;
        ox_reg     <= ox_next;
        oy_reg     <= oy_next;
        olast_reg  <= olast_next;
        otrunc_reg <= otrunc_next;
    end

    // Walk sequencer and output register.
    always_comb
    begin
        state_next  = state_reg;
        cur_next    = cur_reg;
        t_next      = t_reg;
        n_next      = n_reg;
        trunc_next  = trunc_reg;
        prodx_next  = prodx_reg;
        prody_next  = prody_reg;
        ox_next     = ox_reg;
        oy_next     = oy_reg;
        olast_next  = olast_reg;
        otrunc_next = otrunc_reg;
        job_ready   = 1'b0;
        slot_free   = !ovalid_reg || pt.ready;
        ovalid_next = ovalid_reg && !pt.ready;
        step        = (spacing == '0) ? WALK_W'(1) : WALK_W'(spacing);
        px          = walk_coord(cur_reg.start_x, prodx_reg, cur_reg.ux_neg);
        py          = walk_coord(cur_reg.start_y, prody_reg, cur_reg.uy_neg);
        case (state_reg)
            B_IDLE:
            begin
                job_ready = 1'b1;
                if (job_valid)
                begin
                    cur_next   = job;
                    t_next     = '0;
                    n_next     = '0;
                    trunc_next = 1'b0;
                    state_next = B_CHECK;
                end
            end
            B_CHECK:
            begin
                if (t_reg < WALK_W'(cur_reg.seg_len))
                begin
                    if (n_reg == CNT_LAST)
                    begin
                        trunc_next = 1'b1;
                        state_next = B_LAST;
                    end
                    else
                    begin
                        state_next = B_MUL;
                    end
                end
                else
                begin
                    state_next = B_LAST;
                end
            end
            B_MUL:
            begin
                prodx_next = PROD_W'(t_reg * cur_reg.ux_mag);
                prody_next = PROD_W'(t_reg * cur_reg.uy_mag);
                state_next = B_EMIT;
            end
            B_EMIT:
            begin
                if (slot_free)
                begin
                    ovalid_next = 1'b1;
                    ox_next     = px;
                    oy_next     = py;
                    olast_next  = 1'b0;
                    otrunc_next = 1'b0;
                    t_next      = t_reg + step;
                    n_next      = n_reg + CNT_W'(1);
                    state_next  = B_CHECK;
                end
            end
            B_LAST:
            begin
                if (slot_free)
                begin
                    ovalid_next = 1'b1;
                    ox_next     = cur_reg.end_x;
                    oy_next     = cur_reg.end_y;
                    olast_next  = 1'b1;
                    otrunc_next = trunc_reg;
                    state_next  = B_IDLE;
                end
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    assign pt.valid     = ovalid_reg;
    assign pt.point_x   = ox_reg;
    assign pt.point_y   = oy_reg;
    assign pt.is_last   = olast_reg;
    assign pt.truncated = otrunc_reg;

endmodule

`default_nettype wire

// ===== design/line_segment_resampler.sv =====
// Top level of the line segment resampler: spacing register, front end,
// segment queue and back end. Depends on lsr_pkg, lsr_ifs and the submodules.
//
//   channel | dir | word                                  | accepted when
//   seg     | in  | start_x, start_y, end_x, end_y        | valid && ready
//   pt      | out | point_x, point_y, is_last, truncated  | valid && ready
//   cfg     | in  | data (step spacing, Q16.8)            | valid && ready
//
// The front takes a segment, subtracts, squares, sums, runs 25 square root
// steps and two divisions of one setup and 17 steps, and hands it over; it
// skips the divisions when both endpoints are equal. It takes no new segment
// before the last is handed over. The back takes a segment, then checks,
// multiplies and emits per spaced point, and checks again to emit the end point.
// A two-word queue lets the front classify ahead while the back drains.
// Reset is asynchronous and active low; the spacing register resets to 35.0.
// Output stalls hold the back; once the queue is full the front waits with
// its segment and the input stalls until the back takes a queued segment.
`default_nettype none

module line_segment_resampler
    import lsr_pkg::*;
#(
    parameter int MAX_POINTS = 64
)
(
    input  wire logic clk,
    input  wire logic rst_n,
    lsr_seg_if.sink   seg,
    lsr_pt_if.source  pt,
    lsr_cfg_if.sink   cfg
);

    logic [STEP_W-1:0] spacing_reg;
    lsr_job_t          f_job, q_job;
    logic              f_valid, f_ready, q_valid, q_ready;

    // Spacing register, always writable.
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            spacing_reg <= SPACING_RESET;
        end
        else if (cfg.valid)
        begin
            spacing_reg <= cfg.data;
        end
    end

    lsr_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .seg       (seg),
        .job       (f_job),
        .job_valid (f_valid),
        .job_ready (f_ready)
    );

    lsr_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_job   (f_job),
        .push_valid (f_valid),
        .push_ready (f_ready),
        .pop_job    (q_job),
        .pop_valid  (q_valid),
        .pop_ready  (q_ready)
    );

    lsr_back #(.MAX_POINTS(MAX_POINTS)) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job       (q_job),
        .job_valid (q_valid),
        .job_ready (q_ready),
        .spacing   (spacing_reg),
        .pt        (pt)
    );

endmodule

`default_nettype wire

// ===== design/lsr_checker.sv =====
// Port-level checks of the line segment resampler, bound to the top level.
// Depends on lsr_pkg for field widths.
`default_nettype none

module lsr_checker
    import lsr_pkg::*;
(
    input wire logic               clk,
    input wire logic               rst_n,
    input wire logic               seg_valid,
    input wire logic               seg_ready,
    input wire logic               pt_valid,
    input wire logic               pt_ready,
    input wire logic [COORD_W-1:0] pt_x,
    input wire logic [COORD_W-1:0] pt_y,
    input wire logic               pt_last,
    input wire logic               pt_trunc
);

    logic [3:0] open_reg, open_next;

    // Segments accepted whose end point has not been taken yet.
    always_comb
    begin
        open_next = open_reg + {3'd0, seg_valid && seg_ready}
                  - {3'd0, pt_valid && pt_ready && pt_last};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            open_reg <= '0;
        end
        else
        begin
            open_reg <= open_next;
        end
    end

    a_valid_holds: assert property (@(posedge clk) disable iff (!rst_n)
        pt_valid && !pt_ready |=> pt_valid)
        else $error("output word dropped while stalled");

    a_word_holds: assert property (@(posedge clk) disable iff (!rst_n)
        pt_valid && !pt_ready |=> $stable(pt_x) && $stable(pt_y)
                                  && $stable(pt_last) && $stable(pt_trunc))
        else $error("output word changed while stalled");

    a_trunc_on_last: assert property (@(posedge clk) disable iff (!rst_n)
        pt_valid && pt_trunc |-> pt_last)
        else $error("truncated set on a spaced point");

    a_no_orphan: assert property (@(posedge clk) disable iff (!rst_n)
        pt_valid |-> open_reg != 4'd0)
        else $error("output word without an open segment");

endmodule

bind line_segment_resampler lsr_checker u_lsr_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .seg_valid (seg.valid),
    .seg_ready (seg.ready),
    .pt_valid  (pt.valid),
    .pt_ready  (pt.ready),
    .pt_x      (pt.point_x),
    .pt_y      (pt.point_y),
    .pt_last   (pt.is_last),
    .pt_trunc  (pt.truncated)
);

`default_nettype wire
